// ----- sv/mcf_pkg.sv -----
// Package for the magnetometer calibration filter.
// Soft-iron matrix constants, register indexes and helper functions; no dependencies.
`timescale 1ns / 1ps
package mcf_pkg;
    localparam int CFG_OFFSET_X = 0;
    localparam int CFG_OFFSET_Y = 1;
    localparam int CFG_OFFSET_Z = 2;
    localparam int CFG_GAIN     = 3;
    localparam int CFG_WEIGHT   = 4;

    localparam logic signed [17:0] M00 = 18'sd61789;
    localparam logic signed [17:0] M01 = -18'sd533;
    localparam logic signed [17:0] M02 = -18'sd2085;
    localparam logic signed [17:0] M11 = 18'sd65346;
    localparam logic signed [17:0] M12 = -18'sd1057;
    localparam logic signed [17:0] M22 = 18'sd59322;

    // matrix entry for output axis a (row 2,0,1) and column j
    function automatic logic signed [17:0] coef(input logic [1:0] a, input logic [1:0] j);
        logic [3:0] k;
        k = {a, j};
        case (k)
            4'h0: coef = M02;
            4'h1: coef = M12;
            4'h2: coef = M22;
            4'h4: coef = M00;
            4'h5: coef = M01;
            4'h6: coef = M02;
            4'h8: coef = M01;
            4'h9: coef = M11;
            4'hA: coef = M12;
            default: coef = 18'sd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647)
            sat32 = 32'h7fffffff;
        else if (x < -64'sd2147483648)
            sat32 = 32'h80000000;
        else
            sat32 = x[31:0];
    endfunction
endpackage

// ----- sv/magnetometer_calibrate_filter.sv -----
// Magnetometer hard/soft-iron calibration, blend filter and field norm.
// Depends on mcf_pkg.
//
// channel | dir | fields (low bit up)
// s_axis  | in  | tdata: raw_x[23:0], raw_y[47:24], raw_z[71:48]
// m_axis  | out | tuser: status; tdata: filt_a, filt_b, filt_c, field_norm
// cfg     | in  | cfg_we, cfg_index, cfg_data[31:0]
//
// One sample at a time. Every multiply runs through a shared 2-bit-digit
// serial multiplier (a load step, then 17 digit steps); a good sample
// needs 21 multiplies, then a square root and an output state before its
// result is valid. A rejected sample's result is valid the cycle after
// accept. Reset clears state and loads register defaults.
// The input stalls while a result waits on m_axis.
`timescale 1ns / 1ps
module magnetometer_calibrate_filter
    import mcf_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // raw_x, raw_y, raw_z
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata,   // filt_a, filt_b, filt_c, field_norm
    output logic         m_axis_tuser,   // status
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    localparam logic [2:0] S_IDLE = 3'd0, S_MAT = 3'd1, S_GAIN = 3'd2,
                           S_BLD = 3'd3, S_SQ = 3'd4, S_ROOT = 3'd5, S_OUT = 3'd6;

    logic signed [31:0] off_reg [3];
    logic [23:0] gain_reg;
    logic [16:0] wgt_reg;
    logic [23:0] last_raw_reg [3];
    logic signed [31:0] prev_reg [3];
    logic signed [31:0] filt_reg [3];
    logic [31:0] norm_reg;
    logic signed [33:0] d_reg [3];
    logic signed [31:0] cal_reg [3];
    logic [2:0] state_reg;
    logic [1:0] ax_reg, col_reg;
    logic phase_reg;
    logic status_reg, out_v_reg;
    logic signed [63:0] acc_reg;

    // serial multiplier: multiplicand a (64b signed), multiplier b consumed 2b/cycle
    logic signed [63:0] ma_reg, mp_reg;
    logic [33:0] mb_reg;
    logic [5:0] mcnt_reg;
    logic mbusy_reg, mstart;
    logic signed [63:0] st_a;
    logic [33:0] st_b;
    logic [5:0] st_n;
    logic signed [63:0] pp;
    logic [1:0] dig;

    // square root
    logic [63:0] rx_reg, rr_reg, rb_reg;
    logic [5:0] rcnt_reg;

    assign s_axis_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser = status_reg;
    assign m_axis_tdata = {norm_reg, filt_reg[2], filt_reg[1], filt_reg[0]};

    logic [23:0] rin [3];
    assign rin[0] = s_axis_tdata[23:0];
    assign rin[1] = s_axis_tdata[47:24];
    assign rin[2] = s_axis_tdata[71:48];

    logic [16:0] w_eff;
    assign w_eff = wgt_reg[16] ? 17'h10000 : wgt_reg;

    function automatic logic signed [63:0] filt_rs(input logic signed [63:0] x, input int s);
        filt_rs = (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    // multiplier digit: signed two's complement on top digit, unsigned below
    always_comb
    begin
        dig = mb_reg[1:0];
        case (dig)
            2'd0: pp = 64'sd0;
            2'd1: pp = ma_reg;
            2'd2: pp = (mcnt_reg == 6'd1) ? -(ma_reg <<< 1) : (ma_reg <<< 1);
            default: pp = (mcnt_reg == 6'd1) ? -ma_reg : (ma_reg + (ma_reg <<< 1));
        endcase
    end

    always_comb
    begin
        mstart = 1'b0;
        st_a = 64'sd0;
        st_b = 34'd0;
        st_n = 6'd0;
        if (!mbusy_reg && !phase_reg)
        begin
            case (state_reg)
                S_MAT:
                begin
                    mstart = 1'b1;
                    st_a = 64'(coef(ax_reg, col_reg));
                    st_b = d_reg[col_reg];
                    st_n = 6'd17;
                end
                S_GAIN:
                begin
                    mstart = 1'b1;
                    st_a = 64'($signed({1'b0, gain_reg}));
                    st_b = 34'($signed(filt_rs(acc_reg, 16)));
                    st_n = 6'd17;
                end
                S_BLD:
                begin
                    mstart = 1'b1;
                    st_a = col_reg[0] ? 64'($signed({1'b0, 17'h10000 - w_eff}))
                                      : 64'($signed({1'b0, w_eff}));
                    st_b = col_reg[0] ? 34'(prev_reg[ax_reg]) : 34'(cal_reg[ax_reg]);
                    st_n = 6'd17;
                end
                S_SQ:
                begin
                    mstart = 1'b1;
                    st_a = 64'(filt_reg[ax_reg]);
                    st_b = 34'(filt_reg[ax_reg]);
                    st_n = 6'd17;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mbusy_reg <= 1'b0;
            mcnt_reg <= '0;
        end
        else if (mstart)
        begin
            mbusy_reg <= 1'b1;
            mcnt_reg <= st_n;
        end
        else if (mbusy_reg)
        begin
            mcnt_reg <= mcnt_reg - 6'd1;
            if (mcnt_reg == 6'd1)
                mbusy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mstart)
        begin
            ma_reg <= st_a;
            mb_reg <= st_b;
            mp_reg <= 64'sd0;
        end
        else if (mbusy_reg)
        begin
            mp_reg <= mp_reg + (pp <<< (6'd2 * (6'd17 - mcnt_reg)));
            mb_reg <= mb_reg >> 2;
        end
    end

    logic mdone;
    assign mdone = mbusy_reg && mcnt_reg == 6'd1;
    logic signed [63:0] mres;
    assign mres = mp_reg + (pp <<< (6'd2 * (6'd17 - mcnt_reg)));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            status_reg <= 1'b0;
            phase_reg <= 1'b0;
            ax_reg <= '0;
            col_reg <= '0;
            off_reg[0] <= -32'sd128581;
            off_reg[1] <= 32'sd127997;
            off_reg[2] <= -32'sd115842;
            gain_reg <= 24'd8388608;
            wgt_reg <= 17'd32768;
            norm_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                last_raw_reg[i] <= '0;
                prev_reg[i] <= '0;
                filt_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    3'(CFG_OFFSET_X): off_reg[0] <= cfg_data;
                    3'(CFG_OFFSET_Y): off_reg[1] <= cfg_data;
                    3'(CFG_OFFSET_Z): off_reg[2] <= cfg_data;
                    3'(CFG_GAIN):     gain_reg <= cfg_data[23:0];
                    3'(CFG_WEIGHT):   wgt_reg <= cfg_data[16:0];
                    default: ;
                endcase
            end
            if (out_v_reg && m_axis_tready)
                out_v_reg <= 1'b0;
            if (mstart)
                phase_reg <= 1'b1;
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            last_raw_reg[i] <= rin[i];
                            d_reg[i] <= 34'($signed({rin[i], 8'd0})) - 34'(off_reg[i]);
                        end
                        if ((rin[0] == 0 && rin[1] == 0 && rin[2] == 0) ||
                            (rin[0] == last_raw_reg[0] && rin[1] == last_raw_reg[1] &&
                             rin[2] == last_raw_reg[2]))
                        begin
                            status_reg <= 1'b1;
                            out_v_reg <= 1'b1;
                        end
                        else
                        begin
                            status_reg <= 1'b0;
                            state_reg <= S_MAT;
                            ax_reg <= '0;
                            col_reg <= '0;
                            acc_reg <= '0;
                        end
                    end
                end
                S_MAT:
                begin
                    if (mdone)
                    begin
                        phase_reg <= 1'b0;
                        acc_reg <= acc_reg + mres;
                        if (col_reg == 2'd2)
                        begin
                            col_reg <= '0;
                            state_reg <= S_GAIN;
                        end
                        else
                            col_reg <= col_reg + 2'd1;
                    end
                end
                S_GAIN:
                begin
                    if (mdone)
                    begin
                        phase_reg <= 1'b0;
                        cal_reg[ax_reg] <= sat32(filt_rs(mres, 23));
                        acc_reg <= '0;
                        if (ax_reg == 2'd2)
                        begin
                            ax_reg <= '0;
                            state_reg <= S_BLD;
                        end
                        else
                        begin
                            ax_reg <= ax_reg + 2'd1;
                            state_reg <= S_MAT;
                        end
                    end
                end
                S_BLD:
                begin
                    if (mdone)
                    begin
                        phase_reg <= 1'b0;
                        if (!col_reg[0])
                        begin
                            acc_reg <= mres;
                            col_reg <= 2'd1;
                        end
                        else
                        begin
                            filt_reg[ax_reg] <= sat32(filt_rs(acc_reg + mres, 16));
                            prev_reg[ax_reg] <= cal_reg[ax_reg];
                            col_reg <= '0;
                            if (ax_reg == 2'd2)
                            begin
                                ax_reg <= '0;
                                acc_reg <= '0;
                                state_reg <= S_SQ;
                            end
                            else
                                ax_reg <= ax_reg + 2'd1;
                        end
                    end
                end
                S_SQ:
                begin
                    if (mdone)
                    begin
                        phase_reg <= 1'b0;
                        acc_reg <= acc_reg + mres;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= S_ROOT;
                            rcnt_reg <= 6'd32;
                            rx_reg <= acc_reg + mres;
                            rr_reg <= '0;
                            rb_reg <= 64'd1 << 62;
                        end
                        else
                            ax_reg <= ax_reg + 2'd1;
                    end
                end
                S_ROOT:
                begin
                    if (rx_reg >= rr_reg + rb_reg)
                    begin
                        rx_reg <= rx_reg - (rr_reg + rb_reg);
                        rr_reg <= (rr_reg >> 1) + rb_reg;
                    end
                    else
                        rr_reg <= rr_reg >> 1;
                    rb_reg <= rb_reg >> 2;
                    rcnt_reg <= rcnt_reg - 6'd1;
                    if (rcnt_reg == 6'd1)
                        state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    norm_reg <= (rr_reg[63:32] != 0) ? 32'hffffffff : rr_reg[31:0];
                    out_v_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !s_axis_tready)
        else $error("input accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_v_reg && !m_axis_tready) |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_mul_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mbusy_reg)
        else $error("multiplier running while idle");
endmodule
